// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-16 to UTF-8 converter.
// Depends on nothing; defining ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// File: rtl/core/u16u8_pkg.sv
// Types, constants and encoding functions of the UTF-16 to UTF-8 converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package u16u8_pkg;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [15:0] LIMIT_1B   = 16'h0080;
	localparam logic [15:0] LIMIT_2B   = 16'h0800;
	localparam logic [7:0]  LEAD_2B    = 8'hC0;
	localparam logic [7:0]  LEAD_3B    = 8'hE0;
	localparam logic [7:0]  LEAD_4B    = 8'hF0;
	localparam logic [7:0]  CONT       = 8'h80;

	// Most bytes one request can produce: a flushed high surrogate plus a BMP unit.
	localparam int JOB_BYTES   = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      len;
	} bmp_enc_t;

	// Byte list for one request, first byte in entry 0.
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;
		logic                      eos;
	} job_t;

	function automatic bmp_enc_t encode_bmp(input logic [15:0] u);
		bmp_enc_t r;
		r = '0;
		if (u < LIMIT_1B) begin
			r.bytes[0] = u[7:0];
			r.len      = 2'd1;
		end else if (u < LIMIT_2B) begin
			r.bytes[0] = LEAD_2B | {3'b000, u[10:6]};
			r.bytes[1] = CONT | {2'b00, u[5:0]};
			r.len      = 2'd2;
		end else begin
			r.bytes[0] = LEAD_3B | {4'b0000, u[15:12]};
			r.bytes[1] = CONT | {2'b00, u[11:6]};
			r.bytes[2] = CONT | {2'b00, u[5:0]};
			r.len      = 2'd3;
		end
		return r;
	endfunction

	function automatic logic [3:0][7:0] encode_supp(input logic [20:0] cp);
		logic [3:0][7:0] r;
		r[0] = LEAD_4B | {5'b00000, cp[20:18]};
		r[1] = CONT | {2'b00, cp[17:12]};
		r[2] = CONT | {2'b00, cp[11:6]};
		r[3] = CONT | {2'b00, cp[5:0]};
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/u16u8_front.sv
// Front end of the converter: accepts code units, pairs surrogates and builds byte lists.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [15:0]     code_unit,
	input  wire logic            last_unit,
	output logic                 push,
	output u16u8_pkg::job_t      push_job,
	input  wire logic            q_full
);

	logic                  pend_valid_q;
	logic [9:0]            pend_bits_q;
	logic                  is_high;
	logic                  is_low;
	logic                  hold_next;
	logic                  accept;
	logic [20:0]           pair_cp;
	u16u8_pkg::bmp_enc_t   unit_enc;
	u16u8_pkg::bmp_enc_t   held_enc;
	logic [3:0][7:0]       supp_bytes;
	u16u8_pkg::job_t       job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign is_high = (code_unit >= u16u8_pkg::HIGH_FIRST) && (code_unit <= u16u8_pkg::HIGH_LAST);
	assign is_low  = (code_unit >= u16u8_pkg::LOW_FIRST) && (code_unit <= u16u8_pkg::LOW_LAST);

	assign pair_cp    = u16u8_pkg::SUPP_BASE + {1'b0, pend_bits_q, code_unit[9:0]};
	assign unit_enc   = u16u8_pkg::encode_bmp(code_unit);
	assign held_enc   = u16u8_pkg::encode_bmp(u16u8_pkg::HIGH_FIRST | {6'b000000, pend_bits_q});
	assign supp_bytes = u16u8_pkg::encode_supp(pair_cp);

	always_comb begin
		job       = '0;
		job.eos   = last_unit;
		hold_next = 1'b0;
		if (pend_valid_q) begin
			if (is_low) begin
				job.bytes[3:0] = supp_bytes;
				job.count      = 3'd4;
			end else begin
				// The held high surrogate goes out alone before this unit.
				job.bytes[2:0] = held_enc.bytes;
				if (is_high && !last_unit) begin
					hold_next = 1'b1;
					job.count = 3'd3;
				end else begin
					job.bytes[5:3] = unit_enc.bytes;
					job.count      = 3'd3 + {1'b0, unit_enc.len};
				end
			end
		end else if (is_high && !last_unit) begin
			hold_next = 1'b1;
		end else begin
			job.bytes[2:0] = unit_enc.bytes;
			job.count      = {1'b0, unit_enc.len};
		end
	end

	// A request that only stores a high surrogate produces no bytes.
	assign push     = accept && (job.count != 3'd0);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_valid_q <= hold_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_next) begin
			pend_bits_q <= code_unit[9:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/u16u8_queue.sv
// Short queue of byte lists between the front and back ends.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  u16u8_pkg::job_t      push_job,
	output logic                 full,
	input  wire logic            pop,
	output u16u8_pkg::job_t      head,
	output logic                 empty
);

	u16u8_pkg::job_t                  entry_q [u16u8_pkg::QUEUE_DEPTH];
	logic [u16u8_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [u16u8_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [u16u8_pkg::QCNT_W-1:0]     count_q;

	assign full  = (count_q == u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/u16u8_back.sv
// Back end of the converter: walks the head byte list and drives the output register.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  u16u8_pkg::job_t      head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           utf8_byte,
	output logic                 last_of_run,
	output logic                 end_of_string
);

	logic [2:0]  idx_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        run_last_q;
	logic        eos_q;
	logic        load;
	logic        final_byte;

	// The output register takes a new byte whenever it is empty or being drained.
	assign load       = !valid_q || out_ready;
	assign final_byte = (idx_q == (head.count - 3'd1));
	assign pop        = load && !empty && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				idx_q <= final_byte ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			byte_q     <= head.bytes[idx_q];
			run_last_q <= final_byte;
			eos_q      <= final_byte && head.eos;
		end
	end

	assign out_valid     = valid_q;
	assign utf8_byte     = byte_q;
	assign last_of_run   = run_last_q;
	assign end_of_string = eos_q;

endmodule

`default_nettype wire

// File: rtl/core/utf16_to_utf8_converter.sv
// Top level of the UTF-16 to UTF-8 converter: front end, queue and back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back and assert_macros.svh.
`default_nettype none

// Converts a stream of UTF-16 code units into UTF-8 bytes. The input takes one code unit
// per cycle while the four-entry queue has room; the output gives one byte per cycle while
// m_tready is high, so a unit yields one to three bytes, a surrogate pair four, and a lone
// high surrogate followed by another unit up to six. The single-byte output register is
// what sets the sustained rate. A high surrogate is held until the next unit shows whether
// it forms a pair; one that ends the string is sent at once. Lone surrogates are sent as
// three-byte sequences. The first byte of a request is written into a queue entry and
// then loaded into the output register before it is offered on the output.
// tlast marks the last byte of each request and tuser the last byte of the string.

`include "assert_macros.svh"

module utf16_to_utf8_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] code_unit
	input  wire logic        s_tlast,   // last_unit
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] utf8_byte
	output logic             m_tlast,   // last_of_run
	output logic             m_tuser    // [0] end_of_string
);

	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	u16u8_pkg::job_t    q_in_job;
	u16u8_pkg::job_t    q_head;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.code_unit (s_tdata),
		.last_unit (s_tlast),
		.push      (q_push),
		.push_job  (q_in_job),
		.q_full    (q_full)
	);

	u16u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in_job),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.utf8_byte     (m_tdata),
		.last_of_run   (m_tlast),
		.end_of_string (m_tuser)
	);

	`ASSERT_IMPL(a_no_push_when_full, clk, arst_n, q_push, !q_full, "queue written while full")
	`ASSERT_IMPL(a_no_pop_when_empty, clk, arst_n, q_pop, !q_empty, "queue read while empty")
	`ASSERT_IMPL(a_eos_on_run_end, clk, arst_n, m_tvalid && m_tuser, m_tlast, "string end not on a request end")
	`ASSERT_IMPL(a_job_count_range, clk, arst_n, q_push, (q_in_job.count != 3'd0) && (q_in_job.count <= 3'd6), "byte list length out of range")

endmodule

`default_nettype wire
